[src/ism_pkg.sv]
`default_nettype none

package ism_pkg;

  localparam int STACK_DEPTH = 1024;
  localparam int WORD_W      = 32;
  localparam int SP_W        = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int DEPTH_W     = 11;
  localparam int CNT_W       = $clog2(WORD_W);

  typedef enum logic [3:0] {
    ACT_CONST = 4'd0,
    ACT_ADD   = 4'd1,
    ACT_SUB   = 4'd2,
    ACT_MUL   = 4'd3,
    ACT_DIV   = 4'd4,
    ACT_MAX   = 4'd5,
    ACT_MIN   = 4'd6,
    ACT_NEG   = 4'd7,
    ACT_DUP   = 4'd8,
    ACT_SWAP  = 4'd9
  } act_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_OVER  = 2'd2,
    ST_DIVZ  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    K_NONE,
    K_PUSH,
    K_DUP,
    K_NEG,
    K_SWAP,
    K_ALU,
    K_DIV
  } kind_t;

  typedef struct packed {
    logic [3:0]               action;
    logic signed [WORD_W-1:0] push_value;
  } in_beat_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] top_value;
    logic [DEPTH_W-1:0]       depth;
    logic [1:0]               status;
  } out_beat_t;

  typedef struct packed {
    logic    exec;
    logic    div_start;
    kind_t   kind;
    act_t    op;
    status_t err;
  } cmd_t;

  typedef struct packed {
    logic sp_zero;
    logic sp_lt2;
    logic sp_full;
    logic b_zero;
    logic div_done;
  } dp_stat_t;

endpackage

`default_nettype wire

[src/ism_div.sv]
`default_nettype none

module ism_div import ism_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [WORD_W-1:0] a,
  input  wire logic [WORD_W-1:0] b,
  output logic                   done,
  output logic [WORD_W-1:0]      quot
);

  logic [WORD_W-1:0] rem;
  logic [WORD_W-1:0] q;
  logic [WORD_W-1:0] d;
  logic              neg;
  logic [CNT_W-1:0]  cnt;
  logic              run;
  logic [WORD_W:0]   shifted;
  logic [WORD_W:0]   diff;

  assign shifted = {rem, q[WORD_W-1]};
  assign diff    = shifted - {1'b0, d};
  assign quot    = neg ? (WORD_W'(0) - q) : q;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(WORD_W - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // one quotient bit per cycle, restoring
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      q   <= a[WORD_W-1] ? (WORD_W'(0) - a) : a;
      d   <= b[WORD_W-1] ? (WORD_W'(0) - b) : b;
      neg <= a[WORD_W-1] ^ b[WORD_W-1];
    end else if (run) begin
      if (!diff[WORD_W]) begin
        rem <= diff[WORD_W-1:0];
        q   <= {q[WORD_W-2:0], 1'b1};
      end else begin
        rem <= shifted[WORD_W-1:0];
        q   <= {q[WORD_W-2:0], 1'b0};
      end
    end
  end

endmodule

`default_nettype wire

[src/ism_dp.sv]
`default_nettype none

module ism_dp import ism_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     accept,
  input  wire in_beat_t item,
  input  wire cmd_t     cmd,
  output dp_stat_t      stat,
  output out_beat_t     result
);

  // entries below the top live in memory, the top lives in tos
  logic [WORD_W-1:0] mem [STACK_DEPTH];
  logic [SP_W-1:0]   sp;
  logic [WORD_W-1:0] tos;
  logic [WORD_W-1:0] pv;
  logic [WORD_W-1:0] b_q;
  logic [1:0]        status_q;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;
  logic              we;
  logic [WORD_W-1:0] alu;
  logic [WORD_W-1:0] quot;
  logic              div_done;
  logic              a_gt_b;

  assign rd_addr = ADDR_W'(sp - SP_W'(2));
  assign wr_addr = (cmd.kind == K_SWAP) ? ADDR_W'(sp - SP_W'(2)) : ADDR_W'(sp - SP_W'(1));
  assign we = cmd.exec && (((cmd.kind == K_PUSH) && (sp != '0)) ||
                           (cmd.kind == K_DUP) || (cmd.kind == K_SWAP));

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= tos;
    end
    b_q <= mem[rd_addr];
  end

  ism_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .a     (tos),
    .b     (b_q),
    .done  (div_done),
    .quot  (quot)
  );

  assign a_gt_b = $signed(tos) > $signed(b_q);

  always_comb begin
    unique case (cmd.op)
      ACT_ADD: alu = tos + b_q;
      ACT_SUB: alu = tos - b_q;
      ACT_MUL: alu = WORD_W'(tos * b_q);
      ACT_MAX: alu = a_gt_b ? tos : b_q;
      ACT_MIN: alu = a_gt_b ? b_q : tos;
      default: alu = tos;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pv <= item.push_value;
    end
    if (cmd.exec) begin
      status_q <= cmd.err;
      unique case (cmd.kind)
        K_PUSH:  tos <= pv;
        K_NEG:   tos <= WORD_W'(0) - tos;
        K_SWAP:  tos <= b_q;
        K_ALU:   tos <= alu;
        K_DIV:   tos <= quot;
        default: tos <= tos;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sp <= '0;
    end else if (cmd.exec) begin
      unique case (cmd.kind)
        K_PUSH, K_DUP: sp <= sp + SP_W'(1);
        K_ALU, K_DIV:  sp <= sp - SP_W'(1);
        default:       sp <= sp;
      endcase
    end
  end

  assign stat.sp_zero  = (sp == '0);
  assign stat.sp_lt2   = (sp < SP_W'(2));
  assign stat.sp_full  = (sp == SP_W'(STACK_DEPTH));
  assign stat.b_zero   = (b_q == '0);
  assign stat.div_done = div_done;

  assign result.top_value = (sp == '0) ? '0 : tos;
  assign result.depth     = DEPTH_W'(sp);
  assign result.status    = status_q;

endmodule

`default_nettype wire

[src/ism_ctrl.sv]
`default_nettype none

module ism_ctrl import ism_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     accept,
  input  wire logic [3:0] action,
  input  wire dp_stat_t stat,
  output cmd_t          cmd,
  output logic          busy,
  output logic          done
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_DIV,
    S_EXEC
  } state_t;

  state_t state;
  act_t   op;

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      op            <= ACT_CONST;
      done          <= 1'b0;
      cmd.exec      <= 1'b0;
      cmd.div_start <= 1'b0;
      cmd.kind      <= K_NONE;
      cmd.op        <= ACT_CONST;
      cmd.err       <= ST_OK;
    end else begin
      done          <= 1'b0;
      cmd.exec      <= 1'b0;
      cmd.div_start <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op    <= act_t'(action);
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          cmd.op   <= op;
          cmd.err  <= ST_OK;
          cmd.kind <= K_NONE;
          cmd.exec <= 1'b1;
          state    <= S_EXEC;
          unique case (op)
            ACT_CONST: begin
              if (stat.sp_full) begin
                cmd.err <= ST_OVER;
              end else begin
                cmd.kind <= K_PUSH;
              end
            end
            ACT_ADD, ACT_SUB, ACT_MUL, ACT_MAX, ACT_MIN: begin
              if (stat.sp_lt2) begin
                cmd.err <= ST_UNDER;
              end else begin
                cmd.kind <= K_ALU;
              end
            end
            ACT_DIV: begin
              priority if (stat.sp_lt2) begin
                cmd.err <= ST_UNDER;
              end else if (stat.b_zero) begin
                cmd.err <= ST_DIVZ;
              end else begin
                cmd.exec      <= 1'b0;
                cmd.div_start <= 1'b1;
                state         <= S_DIV;
              end
            end
            ACT_NEG: begin
              if (stat.sp_zero) begin
                cmd.err <= ST_UNDER;
              end else begin
                cmd.kind <= K_NEG;
              end
            end
            ACT_DUP: begin
              priority if (stat.sp_zero) begin
                cmd.err <= ST_UNDER;
              end else if (stat.sp_full) begin
                cmd.err <= ST_OVER;
              end else begin
                cmd.kind <= K_DUP;
              end
            end
            ACT_SWAP: begin
              if (stat.sp_lt2) begin
                cmd.err <= ST_UNDER;
              end else begin
                cmd.kind <= K_SWAP;
              end
            end
            default: begin
              cmd.kind <= K_NONE;
            end
          endcase
        end
        S_DIV: begin
          if (stat.div_done) begin
            cmd.kind <= K_DIV;
            cmd.exec <= 1'b1;
            state    <= S_EXEC;
          end
        end
        S_EXEC: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[src/integer_stack_machine.sv]
`default_nettype none

// Stack machine on 32-bit signed words. Raise start with an instruction on item; it is
// taken when busy is low. Exactly one result beat follows, shown for one cycle with
// strobe high: the new top (zero when empty), the depth and a status. The receiver cannot
// stall, so sample result whenever strobe is high. Each instruction passes through the
// evaluate and execute states of the controller, and busy is already low in the result
// cycle, so the next instruction can be issued in it. The cost is set by the controller's
// decode/execute sequence; the top is kept in a register and the entry below it is read
// from the stack memory into a register every cycle, so the memory adds no extra state.
// Divide runs through a restoring divider at one quotient bit per cycle, with busy high
// in the divide state until the quotient is done. No clearing pass is needed after reset.
module integer_stack_machine import ism_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     start,
  output logic          busy,
  input  wire in_beat_t item,
  output logic          strobe,
  output out_beat_t     result
);

  logic     accept;
  cmd_t     cmd;
  dp_stat_t stat;

  assign accept = start && !busy;

  ism_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .action (item.action),
    .stat   (stat),
    .cmd    (cmd),
    .busy   (busy),
    .done   (strobe)
  );

  ism_dp u_dp (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (item),
    .cmd    (cmd),
    .stat   (stat),
    .result (result)
  );

endmodule

`default_nettype wire

[src/ism_chk.sv]
`default_nettype none

module ism_chk import ism_pkg::*; (
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      start,
  input wire logic      busy,
  input wire in_beat_t  item,
  input wire logic      strobe,
  input wire out_beat_t result
);

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("no busy after accepted beat");

  a_strobe_idle: assert property (@(posedge clk) disable iff (rst)
    strobe |-> !busy)
    else $error("result beat while busy");

  a_strobe_single: assert property (@(posedge clk) disable iff (rst)
    strobe |=> !strobe)
    else $error("result beat repeated");

  a_depth_range: assert property (@(posedge clk) disable iff (rst)
    strobe |-> result.depth <= DEPTH_W'(STACK_DEPTH))
    else $error("depth beyond stack size");

  a_empty_top: assert property (@(posedge clk) disable iff (rst)
    strobe && (result.depth == '0) |-> result.top_value == '0)
    else $error("nonzero top on empty stack");

endmodule

bind integer_stack_machine ism_chk u_chk (.*);

`default_nettype wire
